>>> src/fra_pkg.sv
`default_nettype none

package fra_pkg;

    localparam int MAX_RANGES = 128;
    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RESERVE = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_RD_I, S_EX_I, S_RD_J, S_EX_J, S_EV_B, S_EV_C, S_EV_D,
        S_CHK, S_SH_RD, S_SH_WR, S_WR0, S_WR1, S_COMMIT, S_FIN
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_READ, OP_ADV, OP_MARK_I, OP_J_ADV, OP_J_END,
        OP_EVA, OP_EVB, OP_EVC, OP_A_SPLIT, OP_SH_SETUP, OP_SH_RD, OP_SH_WR,
        OP_WR0, OP_WR1, OP_COMMIT, OP_RES_DONE, OP_RES_NOFIT, OP_RES_FULL, OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       empty;
        logic       i_go;
        logic       j_go;
        logic       j_eq_i;
        logic       fit;
        logic       size_zero;
        logic       full;
        logic       need_shift;
        logic       sh_last;
        logic [1:0] p;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> src/fra_datapath.sv
`default_nettype none

module fra_datapath import fra_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_op_t      op,
    output dp_status_t       st,
    input  wire logic [1:0]  s_command,
    input  wire logic [63:0] s_block_size,
    input  wire logic [63:0] s_range_low,
    input  wire logic [63:0] s_range_high,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_address,
    output logic [1:0]       m_status
);

    logic [127:0] mem [MAX_RANGES];

    logic [1:0]  cmd_reg;
    logic [63:0] size_reg, lo_reg, hi_reg;
    logic [4:0]  mask_reg;
    logic [CW-1:0] count_reg, idx_reg, i_reg, j_reg, src_reg, dst_reg;
    logic        right_reg;
    logic [63:0] rd_b_reg, rd_e_reg;
    logic [63:0] first_b_reg, last_e_reg;
    logic [63:0] wb_reg, we_reg, aa_reg, asz_reg;
    logic        ovf_reg, fit_reg;
    logic [63:0] nb0_reg, ne0_reg, nb1_reg, ne1_reg;
    logic [1:0]  p_reg;
    logic [63:0] res_addr_reg;
    logic [1:0]  res_st_reg;
    logic        m_valid_reg;
    logic [63:0] m_address_reg;
    logic [1:0]  m_status_reg;

    logic [CW:0]   new_count, ip;
    logic [64:0]   align_sum;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [127:0]  wr_data;
    logic [CW-1:0] i_plus1;
    logic          span, ca, cb;
    logic [63:0]   a_b, a_e, b_b, b_e;

    assign new_count = {1'b0, count_reg} - ({1'b0, j_reg} - {1'b0, i_reg})
                     + {{(CW-1){1'b0}}, p_reg};
    assign ip        = {1'b0, i_reg} + {{(CW-1){1'b0}}, p_reg};
    assign align_sum = {1'b0, wb_reg} + 65'(mask_reg);
    assign i_plus1   = i_reg + CW'(1);
    assign span      = idx_reg != i_reg;

    always_comb begin
        st.cmd        = cmd_reg;
        st.empty      = lo_reg >= hi_reg;
        st.i_go       = (idx_reg < count_reg) &&
                        ((cmd_reg == CMD_FREE) ? (rd_e_reg < lo_reg) : (rd_e_reg <= lo_reg));
        st.j_go       = (idx_reg < count_reg) &&
                        ((cmd_reg == CMD_FREE) ? (rd_b_reg <= hi_reg) : (rd_b_reg < hi_reg));
        st.j_eq_i     = !span;
        st.fit        = fit_reg;
        st.size_zero  = size_reg == 64'd0;
        st.full       = new_count > (CW+1)'(MAX_RANGES);
        st.need_shift = (j_reg < count_reg) && (ip != {1'b0, j_reg});
        st.sh_last    = right_reg ? (src_reg == j_reg) : (src_reg == count_reg - CW'(1));
        st.p          = p_reg;
        st.out_free   = !m_valid_reg || m_ready;
    end

    // split pieces: "a" keeps the low part, "b" the high part
    always_comb begin
        if (op == OP_A_SPLIT) begin
            ca = rd_b_reg < aa_reg;
            cb = rd_e_reg > asz_reg;
            a_b = rd_b_reg;
            a_e = aa_reg;
            b_b = asz_reg;
            b_e = rd_e_reg;
        end else begin
            ca = first_b_reg < lo_reg;
            cb = last_e_reg > hi_reg;
            a_b = first_b_reg;
            a_e = lo_reg;
            b_b = hi_reg;
            b_e = last_e_reg;
        end
    end

    always_comb begin
        rd_en   = (op == OP_READ) || (op == OP_SH_RD);
        rd_addr = (op == OP_SH_RD) ? src_reg[AW-1:0] : idx_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = dst_reg[AW-1:0];
        wr_data = {rd_b_reg, rd_e_reg};
        case (op)
            OP_SH_WR: begin
                wr_en = 1'b1;
            end
            OP_WR0: begin
                wr_en   = 1'b1;
                wr_addr = i_reg[AW-1:0];
                wr_data = {nb0_reg, ne0_reg};
            end
            OP_WR1: begin
                wr_en   = 1'b1;
                wr_addr = i_plus1[AW-1:0];
                wr_data = {nb1_reg, ne1_reg};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            {rd_b_reg, rd_e_reg} <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            OP_LOAD: begin
                cmd_reg  <= s_command;
                size_reg <= s_block_size;
                lo_reg   <= s_range_low;
                hi_reg   <= s_range_high;
                mask_reg <= (s_block_size <= 64'd8) ? 5'h07 :
                            (s_block_size <= 64'd16) ? 5'h0f : 5'h1f;
                idx_reg  <= '0;
            end
            OP_ADV: idx_reg <= idx_reg + CW'(1);
            OP_MARK_I: i_reg <= idx_reg;
            OP_J_ADV: begin
                if (!span) begin
                    first_b_reg <= rd_b_reg;
                end
                last_e_reg <= rd_e_reg;
                idx_reg    <= idx_reg + CW'(1);
            end
            OP_J_END: begin
                j_reg <= idx_reg;
                if (cmd_reg == CMD_FREE) begin
                    nb0_reg <= (span && first_b_reg < lo_reg) ? first_b_reg : lo_reg;
                    ne0_reg <= (span && last_e_reg > hi_reg) ? last_e_reg : hi_reg;
                    p_reg   <= 2'd1;
                end else begin
                    nb0_reg <= ca ? a_b : b_b;
                    ne0_reg <= ca ? a_e : b_e;
                    nb1_reg <= b_b;
                    ne1_reg <= b_e;
                    p_reg   <= {1'b0, ca} + {1'b0, cb};
                end
            end
            OP_EVA: begin
                wb_reg <= (rd_b_reg > lo_reg) ? rd_b_reg : lo_reg;
                we_reg <= (rd_e_reg < hi_reg) ? rd_e_reg : hi_reg;
            end
            OP_EVB: begin
                ovf_reg <= align_sum[64];
                aa_reg  <= align_sum[63:0] & ~(64'(mask_reg));
            end
            OP_EVC: begin
                fit_reg <= !ovf_reg && (aa_reg <= we_reg) && (size_reg <= we_reg - aa_reg);
                asz_reg <= aa_reg + size_reg;
            end
            OP_A_SPLIT: begin
                i_reg   <= idx_reg;
                j_reg   <= idx_reg + CW'(1);
                nb0_reg <= ca ? a_b : b_b;
                ne0_reg <= ca ? a_e : b_e;
                nb1_reg <= b_b;
                ne1_reg <= b_e;
                p_reg   <= {1'b0, ca} + {1'b0, cb};
            end
            OP_SH_SETUP: begin
                right_reg <= ip > {1'b0, j_reg};
                if (ip > {1'b0, j_reg}) begin
                    src_reg <= count_reg - CW'(1);
                    dst_reg <= count_reg;
                end else begin
                    src_reg <= j_reg;
                    dst_reg <= ip[CW-1:0];
                end
            end
            OP_SH_WR: begin
                if (right_reg) begin
                    src_reg <= src_reg - CW'(1);
                    dst_reg <= dst_reg - CW'(1);
                end else begin
                    src_reg <= src_reg + CW'(1);
                    dst_reg <= dst_reg + CW'(1);
                end
            end
            OP_COMMIT, OP_RES_DONE: begin
                res_addr_reg <= (cmd_reg == CMD_ALLOC) ? aa_reg : 64'd0;
                res_st_reg   <= ST_DONE;
            end
            OP_RES_NOFIT: begin
                res_addr_reg <= hi_reg;
                res_st_reg   <= ST_NOFIT;
            end
            OP_RES_FULL: begin
                res_addr_reg <= (cmd_reg == CMD_ALLOC) ? hi_reg : 64'd0;
                res_st_reg   <= ST_FULL;
            end
            OP_OUT: begin
                m_address_reg <= res_addr_reg;
                m_status_reg  <= res_st_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (op == OP_COMMIT) begin
                count_reg <= new_count[CW-1:0];
            end
            if (op == OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_address = m_address_reg;
    assign m_status  = m_status_reg;

endmodule

`default_nettype wire

>>> src/fra_controller.sv
`default_nettype none

module fra_controller import fra_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t st,
    output dp_op_t          op
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op         = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (st.cmd == CMD_ALLOC ||
                    ((st.cmd == CMD_FREE || st.cmd == CMD_RESERVE) && !st.empty)) begin
                    state_next = S_RD_I;
                end else begin
                    op         = OP_RES_DONE;
                    state_next = S_FIN;
                end
            end
            S_RD_I: begin
                op         = OP_READ;
                state_next = S_EX_I;
            end
            S_EX_I: begin
                if (st.i_go) begin
                    op         = OP_ADV;
                    state_next = S_RD_I;
                end else begin
                    op         = OP_MARK_I;
                    state_next = S_RD_J;
                end
            end
            S_RD_J: begin
                op         = OP_READ;
                state_next = S_EX_J;
            end
            S_EX_J: begin
                if (st.cmd == CMD_ALLOC) begin
                    if (st.j_go) begin
                        op         = OP_EVA;
                        state_next = S_EV_B;
                    end else begin
                        op         = OP_RES_NOFIT;
                        state_next = S_FIN;
                    end
                end else if (st.j_go) begin
                    op         = OP_J_ADV;
                    state_next = S_RD_J;
                end else if (st.cmd == CMD_RESERVE && st.j_eq_i) begin
                    op         = OP_RES_DONE;
                    state_next = S_FIN;
                end else begin
                    op         = OP_J_END;
                    state_next = S_CHK;
                end
            end
            S_EV_B: begin
                op         = OP_EVB;
                state_next = S_EV_C;
            end
            S_EV_C: begin
                op         = OP_EVC;
                state_next = S_EV_D;
            end
            S_EV_D: begin
                if (!st.fit) begin
                    op         = OP_ADV;
                    state_next = S_RD_J;
                end else if (st.size_zero) begin
                    op         = OP_RES_DONE;
                    state_next = S_FIN;
                end else begin
                    op         = OP_A_SPLIT;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (st.full) begin
                    op         = OP_RES_FULL;
                    state_next = S_FIN;
                end else if (st.need_shift) begin
                    op         = OP_SH_SETUP;
                    state_next = S_SH_RD;
                end else if (st.p != 2'd0) begin
                    state_next = S_WR0;
                end else begin
                    state_next = S_COMMIT;
                end
            end
            S_SH_RD: begin
                op         = OP_SH_RD;
                state_next = S_SH_WR;
            end
            S_SH_WR: begin
                op = OP_SH_WR;
                if (!st.sh_last) begin
                    state_next = S_SH_RD;
                end else if (st.p != 2'd0) begin
                    state_next = S_WR0;
                end else begin
                    state_next = S_COMMIT;
                end
            end
            S_WR0: begin
                op         = OP_WR0;
                state_next = (st.p == 2'd2) ? S_WR1 : S_COMMIT;
            end
            S_WR1: begin
                op         = OP_WR1;
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                op         = OP_COMMIT;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (st.out_free) begin
                    op         = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/free_range_allocator.sv
// Free range allocator: keeps up to MAX_RANGES disjoint free ranges [begin,end)
// sorted by begin in a single-port table memory. Commands: allocate (0) takes
// an aligned block (align 8/16/32 by size) from the first fitting range in the
// window and returns its address, or range_high with status no-fit or full;
// free (1) inserts and merges a range; reserve (2) carves a range out. One item
// is worked at a time. Cost is set by the table port: it grows with the entries
// scanned for the start position, the entries in the touched span (the
// candidates on allocate) and the entries moved when the tail shifts. Free
// and reserve scan and shift at most the whole table once; an allocate that
// tries every entry is the worst case. The result sits in an output
// register, so the next item is taken while it waits.
`default_nettype none

module free_range_allocator import fra_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [63:0] s_block_size,
    input  wire logic [63:0] s_range_low,
    input  wire logic [63:0] s_range_high,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_address,
    output logic [1:0]       m_status
);

    dp_op_t     op;
    dp_status_t st;

    // sequencer: scan, evaluate, shift, write back
    fra_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .op      (op)
    );

    // table memory, compare/align units, output register
    fra_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (op),
        .st           (st),
        .s_command    (s_command),
        .s_block_size (s_block_size),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_address    (m_address),
        .m_status     (m_status)
    );

endmodule

`default_nettype wire

>>> src/fra_checker.sv
`default_nettype none

module fra_checker import fra_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_address,
    input wire logic [1:0]  m_status
);

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_DONE || m_status == ST_NOFIT || m_status == ST_FULL))
        else $error("bad status code");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_address) && $stable(m_status))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result with no item in flight");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind free_range_allocator fra_checker u_fra_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

// Scoreboard: a model of the range table that predicts each result
// and a queue of predictions compared in order against the block.
class range_table_sb;
    localparam int DEPTH = fra_pkg::MAX_RANGES;

    logic [63:0] rb[DEPTH];
    logic [63:0] re[DEPTH];
    int          cnt;
    logic [63:0] exp_addr[$];
    logic [1:0]  exp_stat[$];
    int          errors;

    function new();
        cnt = 0;
        errors = 0;
    endfunction

    function int first_reach(logic [63:0] a, bit touch);
        int i;
        i = 0;
        while (i < cnt && (touch ? re[i] < a : re[i] <= a)) i++;
        return i;
    endfunction

    // Replace entries [i,j) by p new ones; 0 when the table would overflow.
    function bit splice(int i, int j, logic [63:0] nb[2], logic [63:0] ne[2], int p);
        logic [63:0] tb[$];
        logic [63:0] te[$];
        int          k;
        if (cnt - (j - i) + p > DEPTH) return 0;
        for (k = 0; k < i; k++) begin tb.push_back(rb[k]); te.push_back(re[k]); end
        for (k = 0; k < p; k++) begin tb.push_back(nb[k]); te.push_back(ne[k]); end
        for (k = j; k < cnt; k++) begin tb.push_back(rb[k]); te.push_back(re[k]); end
        cnt = tb.size();
        for (k = 0; k < cnt; k++) begin rb[k] = tb[k]; re[k] = te[k]; end
        return 1;
    endfunction

    function logic [1:0] free_range(logic [63:0] lo, logic [63:0] hi);
        int          i, j;
        logic [63:0] nb[2];
        logic [63:0] ne[2];
        if (lo >= hi) return fra_pkg::ST_DONE;
        i = first_reach(lo, 1);
        j = i;
        while (j < cnt && rb[j] <= hi) j++;
        nb[0] = lo;
        ne[0] = hi;
        if (j > i) begin
            if (rb[i] < nb[0]) nb[0] = rb[i];
            if (re[j-1] > ne[0]) ne[0] = re[j-1];
        end
        return splice(i, j, nb, ne, 1) ? fra_pkg::ST_DONE : fra_pkg::ST_FULL;
    endfunction

    function logic [1:0] reserve_range(logic [63:0] lo, logic [63:0] hi);
        int          i, j, p;
        logic [63:0] nb[2];
        logic [63:0] ne[2];
        p = 0;
        if (lo >= hi) return fra_pkg::ST_DONE;
        i = first_reach(lo, 0);
        j = i;
        while (j < cnt && rb[j] < hi) j++;
        if (j == i) return fra_pkg::ST_DONE;
        if (rb[i] < lo) begin nb[p] = rb[i]; ne[p] = lo; p++; end
        if (re[j-1] > hi) begin nb[p] = hi; ne[p] = re[j-1]; p++; end
        return splice(i, j, nb, ne, p) ? fra_pkg::ST_DONE : fra_pkg::ST_FULL;
    endfunction

    function void alloc_block(logic [63:0] sz, logic [63:0] lo, logic [63:0] hi,
                              output logic [63:0] addr, output logic [1:0] st);
        logic [63:0] mask, b, e, a;
        logic [63:0] nb[2];
        logic [63:0] ne[2];
        int          i, p;
        mask = (sz <= 8) ? 64'd7 : (sz <= 16) ? 64'd15 : 64'd31;
        for (i = first_reach(lo, 0); i < cnt && rb[i] < hi; i++) begin
            b = rb[i] > lo ? rb[i] : lo;
            e = re[i] < hi ? re[i] : hi;
            p = 0;
            if (b > ~mask) continue;
            a = (b + mask) & ~mask;
            if (a > e || sz > e - a) continue;
            if (sz == 0) begin addr = a; st = fra_pkg::ST_DONE; return; end
            if (rb[i] < a) begin nb[p] = rb[i]; ne[p] = a; p++; end
            if (re[i] > a + sz) begin nb[p] = a + sz; ne[p] = re[i]; p++; end
            if (!splice(i, i + 1, nb, ne, p)) begin
                addr = hi; st = fra_pkg::ST_FULL; return;
            end
            addr = a;
            st = fra_pkg::ST_DONE;
            return;
        end
        addr = hi;
        st = fra_pkg::ST_NOFIT;
    endfunction

    function void note_item(logic [1:0] c, logic [63:0] sz, logic [63:0] lo,
                            logic [63:0] hi);
        logic [63:0] a;
        logic [1:0]  s;
        a = '0;
        s = fra_pkg::ST_DONE;
        case (c)
            fra_pkg::CMD_ALLOC:   alloc_block(sz, lo, hi, a, s);
            fra_pkg::CMD_FREE:    s = free_range(lo, hi);
            fra_pkg::CMD_RESERVE: s = reserve_range(lo, hi);
            default: ;
        endcase
        exp_addr.push_back(a);
        exp_stat.push_back(s);
    endfunction

    function void check_result(logic [63:0] a, logic [1:0] s);
        logic [63:0] ea;
        logic [1:0]  es;
        if (exp_addr.size() == 0) begin
            $error("unexpected result address=%h status=%0d", a, s);
            errors++;
            return;
        end
        ea = exp_addr.pop_front();
        es = exp_stat.pop_front();
        if (a !== ea) begin
            $error("address: expected %h actual %h", ea, a);
            errors++;
        end
        if (s !== es) begin
            $error("status: expected %0d actual %0d", es, s);
            errors++;
        end
    endfunction

    function int pending();
        return exp_addr.size();
    endfunction
endclass

module tb_top;
    import fra_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_FREE;
    logic [63:0] s_block_size = '0;
    logic [63:0] s_range_low = '0;
    logic [63:0] s_range_high = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [63:0] m_address;
    logic [1:0]  m_status;

    range_table_sb sb = new();

    // sender idle control; when quiet, neither side idles
    bit          quiet = 0;
    // receiver hold-off in cycles, served by the receiver process
    int          hold_req = 0;
    bit          stim_done = 0;

    always #5 aclk = ~aclk;

    free_range_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_block_size(s_block_size), .s_range_low(s_range_low),
        .s_range_high(s_range_high),
        .m_valid(m_valid), .m_ready(m_ready), .m_address(m_address),
        .m_status(m_status)
    );

    // Offer one item from a falling edge, hold until accepted at a rising edge.
    // Valid drops only when the sender idles; drain() drops it at the end.
    task automatic send_item(logic [1:0] c, logic [63:0] sz, logic [63:0] lo,
                             logic [63:0] hi);
        if (!quiet && $urandom_range(99) < 15) begin
            s_valid <= 0;
            do @(negedge aclk); while ($urandom_range(99) < 15);
        end
        s_command <= c;
        s_block_size <= sz;
        s_range_low <= lo;
        s_range_high <= hi;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(c, sz, lo, hi);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (800) @(negedge aclk);
    endtask

    // Mostly small sizes, with edge values now and then.
    function automatic logic [63:0] pick_size();
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: return 64'd0;
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            3: return $urandom_range(17, 8);
            default: return $urandom_range(64);
        endcase
    endfunction

    // Addresses cluster in a small window so ranges touch, merge and split;
    // a few go near the top of the space to hit the overflow skips.
    function automatic logic [63:0] pick_addr();
        case ($urandom_range(19))
            0: return {$urandom, $urandom};
            1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(64);
            default: return $urandom_range(4095);
        endcase
    endfunction

    task automatic random_item();
        logic [63:0] lo, hi;
        int          r;
        lo = pick_addr();
        hi = ($urandom_range(9) == 0) ? pick_addr() : lo + $urandom_range(300);
        r = $urandom_range(99);
        if (r < 45) send_item(CMD_ALLOC, pick_size(), lo,
                              ($urandom_range(3) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : hi);
        else if (r < 75) send_item(CMD_FREE, {$urandom, $urandom}, lo, hi);
        else if (r < 97) send_item(CMD_RESERVE, {$urandom, $urandom}, lo, hi);
        else send_item(2'd3, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom});
    endtask

    // Results: random stall, long hold-offs on request, none when quiet.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                m_ready <= 0;
                repeat (hold_req) @(negedge aclk);
                hold_req = 0;
            end
            m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 15);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_address, m_status);
    end

    initial begin
        int k;
        repeat (12) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: empty table, extremes, all commands and special cases.
        send_item(CMD_ALLOC, 64'd8, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);   // nothing free
        send_item(CMD_FREE, '0, 64'd100, 64'd100);                       // empty free
        send_item(CMD_RESERVE, '0, 64'd5, 64'd1);                        // empty reserve
        send_item(CMD_FREE, '0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);         // whole space
        send_item(CMD_ALLOC, 64'd0, 64'd3, 64'd100);                     // size zero
        send_item(CMD_ALLOC, 64'd8, 64'd1, 64'd100);
        send_item(CMD_ALLOC, 64'd9, 64'd1, 64'd100);
        send_item(CMD_ALLOC, 64'd17, 64'd1, 64'd1000);
        send_item(CMD_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_ALLOC, 64'd4, 64'hFFFF_FFFF_FFFF_FFF9,
                  64'hFFFF_FFFF_FFFF_FFFF);                              // align overflow
        send_item(CMD_ALLOC, 64'd4, 64'd500, 64'd200);                   // inverted window
        send_item(CMD_RESERVE, '0, 64'd2000, 64'd3000);                  // split
        send_item(CMD_FREE, '0, 64'd1990, 64'd3010);                     // merge back
        send_item(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF);                              // unused
        send_item(CMD_RESERVE, '0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);      // clear all

        // Fill the table with disjoint ranges, then hit the full cases.
        // Receiver holds off meanwhile so the block backs up.
        hold_req = 400;
        for (k = 0; k < fra_pkg::MAX_RANGES; k++)
            send_item(CMD_FREE, '0, 64'(k * 64), 64'(k * 64 + 32));
        send_item(CMD_FREE, '0, 64'd100000, 64'd100010);                 // free, full
        send_item(CMD_RESERVE, '0, 64'd8, 64'd16);                       // reserve, full
        send_item(CMD_ALLOC, 64'd4, 64'd1, 64'd64);                      // alloc split, full
        send_item(CMD_ALLOC, 64'd32, 64'd0, 64'd64);                     // exact, no split
        send_item(CMD_RESERVE, '0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);

        // Sender pause until every result is in.
        drain();

        // Random part: normal idling with a quiet stretch in the middle.
        for (k = 0; k < 1150; k++) begin
            quiet = (k >= 300 && k < 500);
            if (k == 700) hold_req = 300;
            if (k % 400 == 399) send_item(CMD_RESERVE, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
            else random_item();
        end
        quiet = 0;
        stim_done = 1;
        drain();
        if (sb.errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    // Timeout well above the worst case per item; ample margin for stalls.
    initial begin
        #60ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
